// ===== src/hex8_pkg.sv =====
package hex8_pkg;

	localparam int COORD_BITS = 24;
	localparam int SUM_W      = 28;
	localparam int ADJ_W      = 56;
	localparam int NRM_W      = 112;
	localparam int ACC_W      = 128;
	localparam int OP_W       = 29;
	localparam int PROD_W     = 2 * OP_W;
	localparam int RATIO_W    = 7;
	localparam int Q2_W       = 2 * RATIO_W;
	localparam int CHUNK_W    = 28;

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(6);

	localparam logic [7:0] SIGN_POS_R = 8'b0110_0110;
	localparam logic [7:0] SIGN_POS_S = 8'b1100_1100;
	localparam logic [7:0] SIGN_POS_T = 8'b1111_0000;

	typedef enum logic [2:0] {
		DIR_R    = 3'd0,
		DIR_S    = 3'd1,
		DIR_T    = 3'd2,
		DIR_NONE = 3'd3,
		DIR_SING = 3'd4
	} dir_t;

	typedef enum logic [1:0] {
		SH_0  = 2'd0,
		SH_28 = 2'd1,
		SH_29 = 2'd2,
		SH_56 = 2'd3
	} shift_t;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ADJ  = 8'b0000_0010,
		ST_DET  = 8'b0000_0100,
		ST_NRM  = 8'b0000_1000,
		ST_DEC  = 8'b0001_0000,
		ST_QSQ  = 8'b0010_0000,
		ST_CMP  = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	function automatic logic [1:0] inc3(input logic [1:0] v);
		return (v == 2'd2) ? 2'd0 : v + 2'd1;
	endfunction

	function automatic logic sign_pos(input logic [1:0] axis, input logic [2:0] node);
		logic [7:0] m;
		case (axis)
			2'd0:    m = SIGN_POS_R;
			2'd1:    m = SIGN_POS_S;
			default: m = SIGN_POS_T;
		endcase
		return m[node];
	endfunction

endpackage

// ===== src/hex8_thickness_direction.sv =====
// After the eighth node transfer: adjugate, determinant, norm, decision, ratio square, compare,
// output (a singular element goes from decision straight to output). Input stalls while busy.
// All products go through one shared 29x29 signed multiplier with a 128-bit accumulator,
// one partial product per cycle, sequenced by the state machine.
// Reset (arst_n low) clears sums, node count and the state machine; ratio returns to 6.
module hex8_thickness_direction import hex8_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [RATIO_W-1:0]           cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   direction_code,
	output logic signed [SUM_W-1:0]      thick_x,
	output logic signed [SUM_W-1:0]      thick_y,
	output logic signed [SUM_W-1:0]      thick_z
);

	state_t                     state_q;
	logic [RATIO_W-1:0]         ratio_q;
	logic signed [SUM_W-1:0]    sums_q [0:2][0:2];
	logic [2:0]                 node_cnt_q;
	logic signed [ADJ_W-1:0]    adj_q [0:2][0:2];
	logic [NRM_W-1:0]           nrm_q [0:2];
	logic signed [ACC_W-1:0]    acc_q;
	logic [1:0]                 r_q, k_q, part_q;
	logic                       det_zero_q, fail_q;
	logic [2:0]                 code_q;
	logic [1:0]                 oa_q, ob_q;
	logic [Q2_W-1:0]            q2_q;
	logic                       out_valid_q;
	logic [2:0]                 dir_q;
	logic signed [SUM_W-1:0]    tx_q, ty_q, tz_q;

	logic                       in_xfer, out_free;
	logic signed [SUM_W-1:0]    coord_ext [0:2];
	logic [1:0]                 ra, rb, cu, cv;
	logic signed [OP_W-1:0]     mul_a, mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [ACC_W-1:0]    prod_ext, prod_sh, term, acc_next;
	shift_t                     sh;
	logic                       neg, clr;
	logic [ADJ_W-1:0]           adj_abs;
	logic [1:0]                 oth;
	logic [ACC_W-1:0]           lhs;
	logic [2:0]                 dec_code;
	logic [1:0]                 dec_a, dec_b;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign direction_code = dir_q;
	assign thick_x = tx_q;
	assign thick_y = ty_q;
	assign thick_z = tz_q;

	assign coord_ext[0] = SUM_W'(coord_x);
	assign coord_ext[1] = SUM_W'(coord_y);
	assign coord_ext[2] = SUM_W'(coord_z);

	assign ra = inc3(r_q);
	assign rb = inc3(ra);
	assign cu = inc3(k_q);
	assign cv = inc3(cu);
	assign oth = (r_q == 2'd0) ? oa_q : ob_q;
	assign adj_abs = adj_q[r_q][k_q][ADJ_W-1] ? ADJ_W'(-adj_q[r_q][k_q])
		: ADJ_W'(adj_q[r_q][k_q]);
	assign lhs = ACC_W'({nrm_q[code_q[1:0]], 4'b0000});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sh    = SH_0;
		neg   = 1'b0;
		clr   = 1'b0;
		unique case (state_q)
			ST_ADJ: begin
				clr = (part_q == 2'd0);
				neg = (part_q != 2'd0);
				if (part_q == 2'd0) begin
					mul_a = OP_W'(sums_q[ra][cu]);
					mul_b = OP_W'(sums_q[rb][cv]);
				end else begin
					mul_a = OP_W'(sums_q[ra][cv]);
					mul_b = OP_W'(sums_q[rb][cu]);
				end
			end
			ST_DET: begin
				clr   = (k_q == 2'd0) && (part_q == 2'd0);
				mul_a = OP_W'(sums_q[0][k_q]);
				if (part_q == 2'd0) begin
					mul_b = OP_W'($signed(adj_q[0][k_q][ADJ_W-1:CHUNK_W]));
					sh    = SH_28;
				end else begin
					mul_b = OP_W'({1'b0, adj_q[0][k_q][CHUNK_W-1:0]});
				end
			end
			ST_NRM: begin
				clr = (k_q == 2'd0) && (part_q == 2'd0);
				case (part_q)
					2'd0: begin
						mul_a = OP_W'({1'b0, adj_abs[ADJ_W-1:CHUNK_W]});
						mul_b = OP_W'({1'b0, adj_abs[ADJ_W-1:CHUNK_W]});
						sh    = SH_56;
					end
					2'd1: begin
						mul_a = OP_W'({1'b0, adj_abs[ADJ_W-1:CHUNK_W]});
						mul_b = OP_W'({1'b0, adj_abs[CHUNK_W-1:0]});
						sh    = SH_29;
					end
					default: begin
						mul_a = OP_W'({1'b0, adj_abs[CHUNK_W-1:0]});
						mul_b = OP_W'({1'b0, adj_abs[CHUNK_W-1:0]});
					end
				endcase
			end
			ST_QSQ: begin
				clr   = 1'b1;
				mul_a = OP_W'({1'b0, ratio_q});
				mul_b = OP_W'({1'b0, ratio_q});
			end
			ST_CMP: begin
				clr   = (k_q == 2'd0);
				mul_a = OP_W'({1'b0, q2_q});
				mul_b = OP_W'({1'b0, nrm_q[oth][CHUNK_W*k_q +: CHUNK_W]});
			end
			ST_IDLE, ST_DEC, ST_OUT: begin
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_ext = ACC_W'(prod);

	always_comb begin
		if (state_q == ST_CMP) begin
			case (k_q)
				2'd0:    prod_sh = prod_ext;
				2'd1:    prod_sh = prod_ext <<< 28;
				2'd2:    prod_sh = prod_ext <<< 56;
				default: prod_sh = prod_ext <<< 84;
			endcase
		end else begin
			case (sh)
				SH_0:    prod_sh = prod_ext;
				SH_28:   prod_sh = prod_ext <<< 28;
				SH_29:   prod_sh = prod_ext <<< 29;
				default: prod_sh = prod_ext <<< 56;
			endcase
		end
	end

	assign term     = neg ? -prod_sh : prod_sh;
	assign acc_next = (clr ? '0 : acc_q) + term;

	always_comb begin
		if (nrm_q[0] >= nrm_q[1] && nrm_q[0] >= nrm_q[2]) begin
			dec_code = DIR_R; dec_a = 2'd1; dec_b = 2'd2;
		end else if (nrm_q[1] >= nrm_q[2]) begin
			dec_code = DIR_S; dec_a = 2'd0; dec_b = 2'd2;
		end else begin
			dec_code = DIR_T; dec_a = 2'd0; dec_b = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ratio_q     <= RATIO_RESET;
			node_cnt_q  <= '0;
			r_q         <= '0;
			k_q         <= '0;
			part_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					sums_q[i][j] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						for (int i = 0; i < 3; i++) begin
							for (int j = 0; j < 3; j++) begin
								if (sign_pos(2'(i), node_cnt_q)) begin
									sums_q[i][j] <= sums_q[i][j] + coord_ext[j];
								end else begin
									sums_q[i][j] <= sums_q[i][j] - coord_ext[j];
								end
							end
						end
						node_cnt_q <= node_cnt_q + 3'd1;
						if (node_cnt_q == 3'd7) begin
							state_q <= ST_ADJ;
							r_q     <= '0;
							k_q     <= '0;
							part_q  <= '0;
						end
					end
				end
				ST_ADJ: begin
					if (part_q == 2'd0) begin
						part_q <= 2'd1;
					end else begin
						part_q <= 2'd0;
						k_q    <= inc3(k_q);
						if (k_q == 2'd2) begin
							r_q <= inc3(r_q);
							if (r_q == 2'd2) begin
								state_q <= ST_DET;
							end
						end
					end
				end
				ST_DET: begin
					if (part_q == 2'd0) begin
						part_q <= 2'd1;
					end else begin
						part_q <= 2'd0;
						k_q    <= inc3(k_q);
						if (k_q == 2'd2) begin
							state_q <= ST_NRM;
						end
					end
				end
				ST_NRM: begin
					if (part_q != 2'd2) begin
						part_q <= part_q + 2'd1;
					end else begin
						part_q <= 2'd0;
						k_q    <= inc3(k_q);
						if (k_q == 2'd2) begin
							r_q <= inc3(r_q);
							if (r_q == 2'd2) begin
								state_q <= ST_DEC;
							end
						end
					end
				end
				ST_DEC: begin
					state_q <= det_zero_q ? ST_OUT : ST_QSQ;
				end
				ST_QSQ: begin
					state_q <= ST_CMP;
					r_q     <= '0;
					k_q     <= '0;
				end
				ST_CMP: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						r_q <= r_q + 2'd1;
						if (r_q == 2'd1) begin
							state_q <= ST_OUT;
							r_q     <= '0;
							k_q     <= '0;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						for (int i = 0; i < 3; i++) begin
							for (int j = 0; j < 3; j++) begin
								sums_q[i][j] <= '0;
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q != ST_IDLE && state_q != ST_DEC && state_q != ST_OUT) begin
			acc_q <= acc_next;
		end
		unique case (state_q)
			ST_ADJ: begin
				if (part_q != 2'd0) begin
					adj_q[r_q][k_q] <= ADJ_W'(acc_next);
				end
			end
			ST_DET: begin
				if (k_q == 2'd2 && part_q != 2'd0) begin
					det_zero_q <= (acc_next == '0);
				end
			end
			ST_NRM: begin
				if (k_q == 2'd2 && part_q == 2'd2) begin
					nrm_q[r_q] <= NRM_W'(acc_next);
				end
			end
			ST_DEC: begin
				code_q <= det_zero_q ? DIR_SING : dec_code;
				oa_q   <= dec_a;
				ob_q   <= dec_b;
				fail_q <= 1'b0;
			end
			ST_QSQ: begin
				q2_q <= Q2_W'(acc_next);
			end
			ST_CMP: begin
				if (k_q == 2'd3 && lhs <= ACC_W'(acc_next)) begin
					fail_q <= 1'b1;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					if (code_q == DIR_SING) begin
						dir_q <= DIR_SING;
						tx_q  <= '0;
						ty_q  <= '0;
						tz_q  <= '0;
					end else if (fail_q) begin
						dir_q <= DIR_NONE;
						tx_q  <= '0;
						ty_q  <= '0;
						tz_q  <= '0;
					end else begin
						dir_q <= code_q;
						tx_q  <= sums_q[code_q[1:0]][0];
						ty_q  <= sums_q[code_q[1:0]][1];
						tz_q  <= sums_q[code_q[1:0]][2];
					end
				end
			end
			ST_IDLE: begin
			end
		endcase
	end

	a_zero_thick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (direction_code == DIR_NONE || direction_code == DIR_SING))
		|-> (thick_x == '0 && thick_y == '0 && thick_z == '0))
		else $error("thickness vector not zero for a non-axis result");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

	a_cnt_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (node_cnt_q == '0))
		else $error("node count not wrapped while busy");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && node_cnt_q == 3'd7) |=> (state_q == ST_ADJ))
		else $error("eighth node did not start the element");

endmodule

// ===== tb/tb_hex8_thickness_direction.sv =====
module tb_hex8_thickness_direction;
	import hex8_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [COORD_BITS-1:0] x, y, z;
	} node_t;

	typedef struct {
		dir_t                   code;
		logic signed [SUM_W-1:0] tx, ty, tz;
	} shape_t;

	typedef logic signed [255:0] wint_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [RATIO_W-1:0] cfg_wdata = 0;
	logic in_valid = 0, in_stall;
	logic signed [COORD_BITS-1:0] coord_x = 0, coord_y = 0, coord_z = 0;
	logic out_valid, out_stall = 0;
	logic [2:0] direction_code;
	logic signed [SUM_W-1:0] thick_x, thick_y, thick_z;

	hex8_thickness_direction i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.direction_code(direction_code),
		.thick_x(thick_x), .thick_y(thick_y), .thick_z(thick_z)
	);

	always #2 clk = ~clk;

	node_t  node_q[$];
	shape_t shape_q[$];
	node_t  shown;
	int     send_idle = 0, recv_idle = 0;
	int     errors = 0, elements = 0;
	int     code_seen[5];
	logic   hold_req = 0, hold_seen = 0;
	int     hold_left = 0;

	logic [RATIO_W-1:0] ratio_q = RATIO_RESET;
	longint jac_sum[9];
	int     node_num = 0;
	logic [7:0] pos_mask[3];

	initial begin
		pos_mask[0] = SIGN_POS_R;
		pos_mask[1] = SIGN_POS_S;
		pos_mask[2] = SIGN_POS_T;
		foreach (jac_sum[i]) jac_sum[i] = 0;
		foreach (code_seen[i]) code_seen[i] = 0;
	end

	function automatic void accumulate_node(node_t n);
		longint c[3];
		wint_t row[3][3], adj[3][3], nrm[3], det, lhs, q2;
		int p, q, k1, k2, ax, oa, ob;
		shape_t s;
		c[0] = n.x;
		c[1] = n.y;
		c[2] = n.z;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				jac_sum[i*3+k] += pos_mask[i][node_num] ? c[k] : -c[k];
		if (node_num < 7) begin
			node_num++;
			return;
		end
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) row[i][k] = wint_t'(jac_sum[i*3+k]);
		for (int i = 0; i < 3; i++) begin
			p = (i + 1) % 3;
			q = (i + 2) % 3;
			for (int k = 0; k < 3; k++) begin
				k1 = (k + 1) % 3;
				k2 = (k + 2) % 3;
				adj[i][k] = row[p][k1] * row[q][k2] - row[p][k2] * row[q][k1];
			end
			nrm[i] = adj[i][0] * adj[i][0] + adj[i][1] * adj[i][1] + adj[i][2] * adj[i][2];
		end
		det = row[0][0] * adj[0][0] + row[0][1] * adj[0][1] + row[0][2] * adj[0][2];
		s.tx = 0;
		s.ty = 0;
		s.tz = 0;
		if (det == 0) begin
			s.code = DIR_SING;
		end else begin
			if (nrm[0] >= nrm[1] && nrm[0] >= nrm[2]) begin
				ax = 0; oa = 1; ob = 2;
			end else if (nrm[1] >= nrm[2]) begin
				ax = 1; oa = 0; ob = 2;
			end else begin
				ax = 2; oa = 0; ob = 1;
			end
			q2 = wint_t'(ratio_q) * wint_t'(ratio_q);
			lhs = nrm[ax] * 16;
			if (lhs <= q2 * nrm[oa] || lhs <= q2 * nrm[ob]) begin
				s.code = DIR_NONE;
			end else begin
				s.code = dir_t'(ax);
				s.tx = jac_sum[ax*3];
				s.ty = jac_sum[ax*3+1];
				s.tz = jac_sum[ax*3+2];
			end
		end
		shape_q.push_back(s);
		foreach (jac_sum[i]) jac_sum[i] = 0;
		node_num = 0;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) accumulate_node(shown);
			if (!in_valid || !in_stall) begin
				if (node_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					shown = node_q.pop_front();
					in_valid <= 1;
					coord_x  <= shown.x;
					coord_y  <= shown.y;
					coord_z  <= shown.z;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		shape_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (shape_q.size() == 0) begin
					report_mismatch("unexpected transfer, code", direction_code, -1);
				end else begin
					w = shape_q.pop_front();
					elements++;
					code_seen[w.code]++;
					if (direction_code !== w.code)
						report_mismatch("direction_code", direction_code, w.code);
					if (thick_x !== w.tx) report_mismatch("thick_x", thick_x, w.tx);
					if (thick_y !== w.ty) report_mismatch("thick_y", thick_y, w.ty);
					if (thick_z !== w.tz) report_mismatch("thick_z", thick_z, w.tz);
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= 400;
				out_stall <= 1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	function automatic logic signed [COORD_BITS-1:0] rnd_coord();
		return $urandom();
	endfunction

	// kinds: 0..2 thin along x/y/z, 3 near cube, 4 full random, 5 degenerate
	task automatic push_element(int kind);
		node_t n;
		int dim[3], ctr[3], v[3], nz;
		nz = $urandom_range(3) == 0 ? 0 : $urandom_range(500);
		for (int k = 0; k < 3; k++) begin
			ctr[k] = $signed($urandom_range(8000000)) - 4000000;
			dim[k] = $urandom_range(2000000, 1000);
		end
		if (kind < 3) dim[kind] = $urandom_range(5000, 1);
		if (kind == 3) begin
			dim[1] = dim[0] + $urandom_range(1000);
			dim[2] = dim[0] + $urandom_range(1000);
		end
		if (kind == 5) dim[$urandom_range(2)] = 0;
		for (int i = 0; i < 8; i++) begin
			for (int k = 0; k < 3; k++)
				v[k] = ctr[k] + (pos_mask[k][i] ? dim[k] : -dim[k])
					+ $signed($urandom_range(2 * nz)) - nz;
			n.x = v[0];
			n.y = v[1];
			n.z = v[2];
			if (kind == 4) begin
				n.x = rnd_coord();
				n.y = rnd_coord();
				n.z = rnd_coord();
			end
			if (kind == 5 && $urandom_range(1)) n = '{x: ctr[0], y: ctr[1], z: ctr[2]};
			node_q.push_back(n);
		end
	endtask

	task automatic drain();
		while (node_q.size() > 0 || in_valid || shape_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_ratio(logic [RATIO_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 0;
		ratio_q   = v;
	endtask

	initial begin
		int ratios[6] = '{6, 4, 64, 0, 127, 0};
		node_t n;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		for (int p = 0; p < 6; p++) begin
			send_idle = (p < 2) ? 29 : (p < 4) ? 73 : 0;
			recv_idle = (p < 2) ? 73 : (p < 4) ? 29 : 0;
			if (p > 0) write_ratio(p == 5 ? $urandom_range(127, 1) : ratios[p]);
			if (p == 0) begin
				for (int i = 0; i < 8; i++) begin
					n.x = pos_mask[0][i] ? 24'sh7FFFFF : 24'sh800000;
					n.y = pos_mask[1][i] ? 24'sh7FFFFF : 24'sh800000;
					n.z = pos_mask[2][i] ? 24'sh7FFFFF : 24'sh800000;
					node_q.push_back(n);
				end
				for (int i = 0; i < 8; i++) begin
					n.x = pos_mask[0][i] ? 24'sh7FFFFF : 24'sh800000;
					n.y = pos_mask[1][i] ? 24'sh7FFFFF : 24'sh800000;
					n.z = pos_mask[2][i] ? 1 : -1;
					node_q.push_back(n);
				end
				for (int i = 0; i < 8; i++) node_q.push_back('{x: -1, y: 0, z: 24'sh800000});
			end
			for (int e = 0; e < 34; e++) begin
				push_element($urandom_range(99) < 70 ? $urandom_range(2) : $urandom_range(5, 3));
				if (e == 17 && p == 1) drain();
				if (e == 17 && p == 2) hold_req = ~hold_req;
			end
			drain();
		end
		$display("elements checked: %0d (r %0d, s %0d, t %0d, not shell %0d, singular %0d)",
			elements, code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4]);
		$display("ratio settings 6, 4, 64, 0, 127 and random; mismatches: %0d", errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/hex8_pkg.sv
src/hex8_thickness_direction.sv
tb/tb_hex8_thickness_direction.sv
